// ----- hw/rtl/mwem_pkg.sv -----
// Shared constants, codes and types for the Microwire EEPROM master.
package mwem_pkg;

   // Memory organization
   localparam int ADDRESS_BITS = 11;
   localparam int DATA_BITS    = 8;

   // Port field widths
   localparam int ACTION_W  = 3;
   localparam int ADDR_W    = 11;
   localparam int WDATA_W   = 8;
   localparam int RDATA_W   = 8;
   localparam int HALF_W    = 8;
   localparam int TIMEOUT_W = 24;

   // Frame shifter: start bit, 2-bit opcode, address, data
   localparam int FRAME_W = 3 + ADDRESS_BITS + DATA_BITS;
   localparam int BITS_W  = $clog2(FRAME_W + 1);
   localparam int IDX_W   = $clog2(FRAME_W);

   // Start bit plus opcode for each command
   localparam logic [2:0] HDR_READ  = 3'b110;
   localparam logic [2:0] HDR_WRITE = 3'b101;
   localparam logic [2:0] HDR_MISC  = 3'b100;
   localparam logic [1:0] SUB_EWEN  = 2'b11;
   localparam logic [1:0] SUB_EWDS  = 2'b00;

   // Action codes on the request beat
   localparam logic [ACTION_W-1:0] ACT_NONE  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_EWEN  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_EWDS  = 3'd4;

   // Sequencer phases
   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_GAP     = 4'd1;
   localparam logic [3:0] PH_SK_LOW  = 4'd2;
   localparam logic [3:0] PH_SK_HIGH = 4'd3;
   localparam logic [3:0] PH_RD_LOW  = 4'd4;
   localparam logic [3:0] PH_RD_HIGH = 4'd5;
   localparam logic [3:0] PH_WR_GAP  = 4'd6;
   localparam logic [3:0] PH_WAIT    = 4'd7;
   localparam logic [3:0] PH_TAIL    = 4'd8;

   // Command kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   // CSR register select (paddr bit 2)
   localparam logic CSR_HALF_BIT = 1'b0;
   localparam logic CSR_TIMEOUT  = 1'b1;

   localparam int RSP_DATA_W = 16;
   localparam int REQ_DATA_W = 24;

   // One result beat, chip_select in bit 0
   typedef struct packed {
      logic               status;
      logic [RDATA_W-1:0] read_data;
      logic               done;
      logic               busy;
      logic               serial_out;
      logic               serial_clock;
      logic               chip_select;
   } rsp_fields_type;

endpackage

// ----- hw/rtl/mwem_seq.sv -----
// Command sequencer: state registers and the one-tick next-state logic.
module mwem_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [mwem_pkg::ACTION_W-1:0]       action,
   input  logic [mwem_pkg::ADDR_W-1:0]         address,
   input  logic [mwem_pkg::WDATA_W-1:0]        write_data,
   input  logic                                serial_in,
   input  logic [mwem_pkg::HALF_W-1:0]         half_bit_ticks,
   input  logic [mwem_pkg::TIMEOUT_W-1:0]      busy_timeout_ticks,
   output mwem_pkg::rsp_fields_type            res
);

   logic [3:0]                          phase_ff, phase_in;
   logic [mwem_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic [mwem_pkg::BITS_W-1:0]         bits_ff, bits_in;
   logic [mwem_pkg::HALF_W-1:0]         delay_ff, delay_in;
   logic [mwem_pkg::TIMEOUT_W-1:0]      tmo_ff, tmo_in;
   logic [mwem_pkg::DATA_BITS-1:0]      rshift_ff, rshift_in;
   logic                                lstat_ff, lstat_in;
   logic [1:0]                          kind_ff, kind_in;

   logic                                expired;
   logic [mwem_pkg::HALF_W-1:0]         delay_dec;
   logic [mwem_pkg::BITS_W-1:0]         bits_dec;
   logic [mwem_pkg::IDX_W-1:0]          bit_idx;
   logic                                frame_msb;
   logic [mwem_pkg::TIMEOUT_W-1:0]      tmo_inc;
   logic [mwem_pkg::ADDRESS_BITS-1:0]   addr_a;
   logic [mwem_pkg::DATA_BITS-1:0]      wdata_d;
   logic                                cs, sk, di, done, stat;

   // timed phase helpers
   assign expired   = (delay_ff <= mwem_pkg::HALF_W'(1));
   assign delay_dec = delay_ff - mwem_pkg::HALF_W'(1);
   assign bits_dec  = (bits_ff != '0) ? bits_ff - mwem_pkg::BITS_W'(1) : '0;
   assign bit_idx   = mwem_pkg::IDX_W'(bits_ff - mwem_pkg::BITS_W'(1));
   assign frame_msb = (bits_ff == '0 || bits_ff > mwem_pkg::BITS_W'(mwem_pkg::FRAME_W))
                      ? 1'b0 : frame_ff[bit_idx];
   assign tmo_inc   = (tmo_ff != {mwem_pkg::TIMEOUT_W{1'b1}})
                      ? tmo_ff + mwem_pkg::TIMEOUT_W'(1) : tmo_ff;
   assign addr_a    = address[mwem_pkg::ADDRESS_BITS-1:0];
   assign wdata_d   = mwem_pkg::DATA_BITS'(write_data);

   // next state for one tick
   always_comb begin
      phase_in  = phase_ff;
      frame_in  = frame_ff;
      bits_in   = bits_ff;
      delay_in  = delay_ff;
      tmo_in    = tmo_ff;
      rshift_in = rshift_ff;
      lstat_in  = lstat_ff;
      kind_in   = kind_ff;
      cs   = 1'b0;
      sk   = 1'b0;
      di   = 1'b0;
      done = 1'b0;
      stat = 1'b0;
      case (phase_ff)
         mwem_pkg::PH_IDLE: begin
            if (action inside {mwem_pkg::ACT_READ, mwem_pkg::ACT_WRITE,
                               mwem_pkg::ACT_EWEN, mwem_pkg::ACT_EWDS}) begin
               bits_in = mwem_pkg::BITS_W'(3 + mwem_pkg::ADDRESS_BITS);
               kind_in = mwem_pkg::KIND_OTHER;
               case (action)
                  mwem_pkg::ACT_READ: begin
                     frame_in = mwem_pkg::FRAME_W'({mwem_pkg::HDR_READ, addr_a});
                     kind_in  = mwem_pkg::KIND_READ;
                  end
                  mwem_pkg::ACT_WRITE: begin
                     frame_in = mwem_pkg::FRAME_W'({mwem_pkg::HDR_WRITE, addr_a, wdata_d});
                     bits_in  = mwem_pkg::BITS_W'(mwem_pkg::FRAME_W);
                     kind_in  = mwem_pkg::KIND_WRITE;
                  end
                  mwem_pkg::ACT_EWEN: begin
                     frame_in = mwem_pkg::FRAME_W'({mwem_pkg::HDR_MISC, mwem_pkg::SUB_EWEN,
                                                    {(mwem_pkg::ADDRESS_BITS-2){1'b0}}});
                  end
                  default: begin
                     frame_in = mwem_pkg::FRAME_W'({mwem_pkg::HDR_MISC, mwem_pkg::SUB_EWDS,
                                                    {(mwem_pkg::ADDRESS_BITS-2){1'b0}}});
                  end
               endcase
               lstat_in = 1'b0;
               tmo_in   = '0;
               phase_in = mwem_pkg::PH_GAP;
               delay_in = half_bit_ticks;
            end
         end
         mwem_pkg::PH_GAP: begin
            if (expired) begin
               phase_in = mwem_pkg::PH_SK_LOW;
               delay_in = half_bit_ticks;
            end else begin
               delay_in = delay_dec;
            end
         end
         mwem_pkg::PH_SK_LOW: begin
            cs = 1'b1;
            di = frame_msb;
            if (expired) begin
               phase_in = mwem_pkg::PH_SK_HIGH;
               delay_in = half_bit_ticks;
            end else begin
               delay_in = delay_dec;
            end
         end
         mwem_pkg::PH_SK_HIGH: begin
            cs = 1'b1;
            sk = 1'b1;
            di = frame_msb;
            if (expired) begin
               bits_in  = bits_dec;
               delay_in = half_bit_ticks;
               if (bits_dec != '0) begin
                  phase_in = mwem_pkg::PH_SK_LOW;
               end else if (kind_ff == mwem_pkg::KIND_READ) begin
                  rshift_in = '0;
                  bits_in   = mwem_pkg::BITS_W'(mwem_pkg::DATA_BITS);
                  phase_in  = mwem_pkg::PH_RD_LOW;
               end else if (kind_ff == mwem_pkg::KIND_WRITE) begin
                  phase_in = mwem_pkg::PH_WR_GAP;
               end else begin
                  phase_in = mwem_pkg::PH_TAIL;
               end
            end else begin
               delay_in = delay_dec;
            end
         end
         mwem_pkg::PH_RD_LOW: begin
            cs = 1'b1;
            if (expired) begin
               phase_in = mwem_pkg::PH_RD_HIGH;
               delay_in = half_bit_ticks;
            end else begin
               delay_in = delay_dec;
            end
         end
         mwem_pkg::PH_RD_HIGH: begin
            cs = 1'b1;
            sk = 1'b1;
            if (expired) begin
               // sample on the last tick of the high half
               rshift_in = {rshift_ff[mwem_pkg::DATA_BITS-2:0], serial_in};
               bits_in   = bits_dec;
               delay_in  = half_bit_ticks;
               phase_in  = (bits_dec != '0) ? mwem_pkg::PH_RD_LOW : mwem_pkg::PH_TAIL;
            end else begin
               delay_in = delay_dec;
            end
         end
         mwem_pkg::PH_WR_GAP: begin
            if (expired) begin
               tmo_in   = '0;
               phase_in = mwem_pkg::PH_WAIT;
            end else begin
               delay_in = delay_dec;
            end
         end
         mwem_pkg::PH_WAIT: begin
            cs = 1'b1;
            if (serial_in) begin
               lstat_in = 1'b0;
               phase_in = mwem_pkg::PH_TAIL;
               delay_in = half_bit_ticks;
            end else begin
               tmo_in = tmo_inc;
               if (tmo_inc >= busy_timeout_ticks) begin
                  lstat_in = 1'b1;
                  phase_in = mwem_pkg::PH_TAIL;
                  delay_in = half_bit_ticks;
               end
            end
         end
         mwem_pkg::PH_TAIL: begin
            if (expired) begin
               done     = 1'b1;
               stat     = lstat_ff;
               phase_in = mwem_pkg::PH_IDLE;
               kind_in  = mwem_pkg::KIND_NONE;
            end else begin
               delay_in = delay_dec;
            end
         end
         default: begin
            phase_in = mwem_pkg::PH_IDLE;
         end
      endcase
   end

   // pins show this tick's phase; busy and read_data reflect the state after this tick
   always_comb begin
      res.chip_select  = cs;
      res.serial_clock = sk;
      res.serial_out   = di;
      res.busy         = (phase_in != mwem_pkg::PH_IDLE);
      res.done         = done;
      res.read_data    = rshift_in[mwem_pkg::RDATA_W-1:0];
      res.status       = stat;
   end

   // state registers advance once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mwem_pkg::PH_IDLE;
         frame_ff  <= '0;
         bits_ff   <= '0;
         delay_ff  <= '0;
         tmo_ff    <= '0;
         rshift_ff <= '0;
         lstat_ff  <= 1'b0;
         kind_ff   <= mwem_pkg::KIND_NONE;
      end else if (step) begin
         phase_ff  <= phase_in;
         frame_ff  <= frame_in;
         bits_ff   <= bits_in;
         delay_ff  <= delay_in;
         tmo_ff    <= tmo_in;
         rshift_ff <= rshift_in;
         lstat_ff  <= lstat_in;
         kind_ff   <= kind_in;
      end
   end

endmodule

// ----- hw/rtl/mwem_out_buf.sv -----
// Result register with a skid stage between the sequencer and the rsp channel.
module mwem_out_buf (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  mwem_pkg::rsp_fields_type  in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output mwem_pkg::rsp_fields_type  out_data
);

   logic                      main_valid_ff, main_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   mwem_pkg::rsp_fields_type  main_data_ff, main_data_in;
   mwem_pkg::rsp_fields_type  skid_data_ff, skid_data_in;
   logic                      in_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // refill main from skid first, else from the incoming beat
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_fire;
            main_data_in  = in_data;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ----- hw/rtl/microwire_eeprom_master_top.sv -----
// Top level of the Microwire EEPROM master: CSRs, sequencer and result buffer.
//
//   channel   direction  beat contents
//   req       in         one tick: action (tuser), address, write_data, serial_in
//   rsp       out        pin levels, busy, done, read_data, status for that tick
//   csr       in/out     APB-style access to half_bit_ticks and busy_timeout_ticks
//
// One req beat is taken per clock and yields exactly one rsp beat; the sequencer
// state advances in the same cycle, the result lands in the output register.
// The skid stage keeps req_tready high for one more beat while rsp is stalled;
// with both output slots full req_tready drops until rsp_tready returns.
// Reset is synchronous; after it the sequencer is idle and the CSRs hold 4 and
// 100000. No clearing pass is needed.
module microwire_eeprom_master_top (
   input  logic                                clock,
   input  logic                                reset,
   // req: tdata = address[10:0], write_data[18:11], serial_in[19], zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mwem_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req: tuser = action[2:0]
   input  logic [mwem_pkg::ACTION_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp: tdata = chip_select[0], serial_clock[1], serial_out[2], busy_res[3],
   //      done_res[4], read_data[12:5], status[13], zero pad
   output logic [mwem_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [mwem_pkg::HALF_W-1:0]     half_ff, half_in;
   logic [mwem_pkg::TIMEOUT_W-1:0]  tmo_cfg_ff, tmo_cfg_in;
   logic                            csr_wr;
   logic                            step;
   mwem_pkg::rsp_fields_type        seq_res;
   mwem_pkg::rsp_fields_type        buf_res;

   // CSR write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      half_in    = half_ff;
      tmo_cfg_in = tmo_cfg_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            mwem_pkg::CSR_HALF_BIT: half_in    = csr_pwdata[mwem_pkg::HALF_W-1:0];
            mwem_pkg::CSR_TIMEOUT:  tmo_cfg_in = csr_pwdata[mwem_pkg::TIMEOUT_W-1:0];
            default:                half_in    = half_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         mwem_pkg::CSR_HALF_BIT: csr_prdata = 32'(half_ff);
         mwem_pkg::CSR_TIMEOUT:  csr_prdata = 32'(tmo_cfg_ff);
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff    <= mwem_pkg::HALF_W'(4);
         tmo_cfg_ff <= mwem_pkg::TIMEOUT_W'(100000);
      end else begin
         half_ff    <= half_in;
         tmo_cfg_ff <= tmo_cfg_in;
      end
   end

   // sequencer steps on every accepted req beat
   assign step = req_tvalid && req_tready;

   mwem_seq u_seq (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .action             (req_tuser),
      .address            (req_tdata[10:0]),
      .write_data         (req_tdata[18:11]),
      .serial_in          (req_tdata[19]),
      .half_bit_ticks     (half_ff),
      .busy_timeout_ticks (tmo_cfg_ff),
      .res                (seq_res)
   );

   mwem_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (seq_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_res)
   );

   assign rsp_tdata = mwem_pkg::RSP_DATA_W'(buf_res);

   // done ends a command, so the block is no longer busy on that tick
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      step && seq_res.done |-> !seq_res.busy)
      else $error("done reported while still busy");

   // timeout status only shows with done
   a_status_with_done: assert property (@(posedge clock) disable iff (reset)
      step && seq_res.status |-> seq_res.done)
      else $error("status set without done");

   // serial clock only toggles while the part is selected
   a_sk_needs_cs: assert property (@(posedge clock) disable iff (reset)
      step && seq_res.serial_clock |-> seq_res.chip_select)
      else $error("serial clock high with chip select low");

   // input stalls only when both output slots hold results
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with empty output register");

endmodule

// ----- tb/sv/microwire_eeprom_master_top_tb.sv -----
// Self-checking testbench for the Microwire EEPROM master: tick stream in, pin/status beats out.
module microwire_eeprom_master_top_tb;
   import mwem_pkg::*;

   // serial_in choices for ticks outside the ready wait
   localparam int SIN_RANDOM   = 0;
   localparam int SIN_HIGH     = 1;
   localparam int SIN_LOW      = 2;
   localparam int NEVER_READY  = -1;
   localparam int RANDOM_TICKS = 200;
   localparam int DRAIN_CYCLES = 8;
   localparam int ACT_CODES    = 1 << ACTION_W;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [ACTION_W-1:0]    req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [2:0]             csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   microwire_eeprom_master_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sequencer model state and its copy of the CSRs
   logic [3:0]           seq_phase;
   logic [FRAME_W-1:0]   seq_frame;
   logic [BITS_W-1:0]    seq_bits_left;
   logic [HALF_W-1:0]    seq_delay;
   logic [TIMEOUT_W-1:0] seq_wait_count;
   logic [RDATA_W-1:0]   seq_read_byte;
   logic                 seq_status;
   logic [1:0]           seq_kind;
   logic                 pin_cs, pin_sk, pin_di;
   logic [HALF_W-1:0]    half_ticks_cfg;
   logic [TIMEOUT_W-1:0] ready_limit_cfg;

   rsp_fields_type expected_tick_q[$];
   rsp_fields_type got_beat, want_beat;
   int             mismatches = 0;
   int             rsp_beats = 0;
   int             ticks_sent = 0;
   bit             gaps_on = 1'b1;
   int             rsp_hold_cycles = 0;
   int             rsp_stall_left = 0;
   int             stall_pick;

   function automatic void set_pins(logic cs, logic sk, logic di);
      pin_cs = cs;
      pin_sk = sk;
      pin_di = di;
   endfunction

   function automatic void phase_enter(logic [3:0] ph);
      seq_phase = ph;
      seq_delay = half_ticks_cfg;
   endfunction

   // true on the last tick of a timed phase; zero counts as one tick
   function automatic bit half_elapsed();
      if (seq_delay <= 1) return 1'b1;
      seq_delay = seq_delay - 1'b1;
      return 1'b0;
   endfunction

   function automatic logic frame_bit();
      if (seq_bits_left == 0) return 1'b0;
      return seq_frame[seq_bits_left - 1];
   endfunction

   // One tick of the sequencer; returns the beat the block should emit for it
   function automatic rsp_fields_type predict_tick(logic [ACTION_W-1:0] act,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [WDATA_W-1:0] wdata,
                                                   logic sin);
      rsp_fields_type r;
      logic           done_now;
      logic           stat_now;
      bit             started;
      done_now = 1'b0;
      stat_now = 1'b0;
      started  = 1'b1;
      case (seq_phase)
         PH_IDLE: begin
            set_pins(1'b0, 1'b0, 1'b0);
            case (act)
               ACT_READ: begin
                  seq_frame     = FRAME_W'({HDR_READ, addr});
                  seq_bits_left = BITS_W'(3 + ADDRESS_BITS);
                  seq_kind      = KIND_READ;
               end
               ACT_WRITE: begin
                  seq_frame     = {HDR_WRITE, addr, wdata};
                  seq_bits_left = BITS_W'(FRAME_W);
                  seq_kind      = KIND_WRITE;
               end
               ACT_EWEN: begin
                  seq_frame     = FRAME_W'({HDR_MISC, SUB_EWEN, {(ADDRESS_BITS-2){1'b0}}});
                  seq_bits_left = BITS_W'(3 + ADDRESS_BITS);
                  seq_kind      = KIND_OTHER;
               end
               ACT_EWDS: begin
                  seq_frame     = FRAME_W'({HDR_MISC, SUB_EWDS, {(ADDRESS_BITS-2){1'b0}}});
                  seq_bits_left = BITS_W'(3 + ADDRESS_BITS);
                  seq_kind      = KIND_OTHER;
               end
               default: started = 1'b0;
            endcase
            if (started) begin
               seq_status     = 1'b0;
               seq_wait_count = '0;
               phase_enter(PH_GAP);
            end
         end
         PH_GAP: begin
            set_pins(1'b0, 1'b0, 1'b0);
            if (half_elapsed()) phase_enter(PH_SK_LOW);
         end
         PH_SK_LOW: begin
            set_pins(1'b1, 1'b0, frame_bit());
            if (half_elapsed()) phase_enter(PH_SK_HIGH);
         end
         PH_SK_HIGH: begin
            set_pins(1'b1, 1'b1, frame_bit());
            if (half_elapsed()) begin
               if (seq_bits_left != 0) seq_bits_left = seq_bits_left - 1'b1;
               if (seq_bits_left != 0) begin
                  phase_enter(PH_SK_LOW);
               end else if (seq_kind == KIND_READ) begin
                  seq_read_byte = '0;
                  seq_bits_left = BITS_W'(DATA_BITS);
                  phase_enter(PH_RD_LOW);
               end else if (seq_kind == KIND_WRITE) begin
                  phase_enter(PH_WR_GAP);
               end else begin
                  phase_enter(PH_TAIL);
               end
            end
         end
         PH_RD_LOW: begin
            set_pins(1'b1, 1'b0, 1'b0);
            if (half_elapsed()) phase_enter(PH_RD_HIGH);
         end
         PH_RD_HIGH: begin
            set_pins(1'b1, 1'b1, 1'b0);
            if (half_elapsed()) begin
               seq_read_byte = {seq_read_byte[RDATA_W-2:0], sin};
               if (seq_bits_left != 0) seq_bits_left = seq_bits_left - 1'b1;
               if (seq_bits_left != 0) phase_enter(PH_RD_LOW);
               else phase_enter(PH_TAIL);
            end
         end
         PH_WR_GAP: begin
            set_pins(1'b0, 1'b0, 1'b0);
            if (half_elapsed()) begin
               seq_wait_count = '0;
               seq_phase      = PH_WAIT;
            end
         end
         PH_WAIT: begin
            set_pins(1'b1, 1'b0, 1'b0);
            if (sin) begin
               seq_status = 1'b0;
               phase_enter(PH_TAIL);
            end else begin
               if (seq_wait_count != '1) seq_wait_count = seq_wait_count + 1'b1;
               if (seq_wait_count >= ready_limit_cfg) begin
                  seq_status = 1'b1;
                  phase_enter(PH_TAIL);
               end
            end
         end
         PH_TAIL: begin
            set_pins(1'b0, 1'b0, 1'b0);
            if (half_elapsed()) begin
               done_now  = 1'b1;
               stat_now  = seq_status;
               seq_phase = PH_IDLE;
               seq_kind  = KIND_NONE;
            end
         end
         default: begin
            set_pins(1'b0, 1'b0, 1'b0);
            seq_phase = PH_IDLE;
         end
      endcase
      r.chip_select  = pin_cs;
      r.serial_clock = pin_sk;
      r.serial_out   = pin_di;
      r.busy         = (seq_phase != PH_IDLE);
      r.done         = done_now;
      r.read_data    = seq_read_byte;
      r.status       = stat_now;
      return r;
   endfunction

   task automatic note_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatches++;
   endtask

   task automatic check_field(input string what, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         note_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", what, got, want));
   endtask

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic pick_sin(int mode);
      case (mode)
         SIN_HIGH: return 1'b1;
         SIN_LOW:  return 1'b0;
         default:  return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // Send one tick beat; the expectation is queued once the beat is taken
   task automatic send_tick(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                            input logic [WDATA_W-1:0] wdata, input logic sin);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= REQ_DATA_W'({sin, wdata, addr});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_tick_q.push_back(predict_tick(act, addr, wdata, sin));
      ticks_sent++;
   endtask

   // Start a command, then keep ticking until the sequencer is idle again.
   // ready_wait counts not-ready ticks in the ready wait before serial_in goes high.
   task automatic run_command(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                              input logic [WDATA_W-1:0] wdata, input int ready_wait,
                              input int sin_mode, input bit noisy);
      int   waited;
      logic s;
      waited = 0;
      send_tick(act, addr, wdata, pick_sin(sin_mode));
      while (seq_phase != PH_IDLE) begin
         if (seq_phase == PH_WAIT) begin
            s = (ready_wait >= 0 && waited >= ready_wait);
            waited++;
         end else begin
            s = pick_sin(sin_mode);
         end
         if (noisy)
            send_tick(ACTION_W'($urandom_range(0, ACT_CODES - 1)),
                      ADDR_W'($urandom_range(0, 2047)),
                      WDATA_W'($urandom_range(0, 255)), s);
         else
            send_tick(ACT_NONE, ADDR_W'($urandom_range(0, 2047)),
                      WDATA_W'($urandom_range(0, 255)), s);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_tick_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_read_check(input logic idx);
      int unsigned want;
      want = (idx == CSR_HALF_BIT) ? half_ticks_cfg : ready_limit_cfg;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field($sformatf("csr read 0x%0h", {idx, 2'b00}), csr_prdata, want);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Register writes happen only with nothing in flight
   task automatic csr_write(input logic idx, input logic [31:0] value);
      drain_results();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == CSR_HALF_BIT) half_ticks_cfg = value[HALF_W-1:0];
      else ready_limit_cfg = value[TIMEOUT_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read_check(idx);
   endtask

   task automatic test_reset_values();
      int code;
      csr_read_check(CSR_HALF_BIT);
      csr_read_check(CSR_TIMEOUT);
      // unused codes and plain ticks leave the sequencer idle
      for (code = ACT_EWDS + 1; code < ACT_CODES; code++)
         run_command(ACTION_W'(code), 11'h7FF, 8'hFF, 0, SIN_HIGH, 1'b0);
      run_command(ACT_NONE, 11'h000, 8'h00, 0, SIN_LOW, 1'b0);
   endtask

   task automatic test_each_command();
      // one command at the reset half-bit time, the rest at the shortest one
      run_command(ACT_EWEN, 11'h000, 8'h00, 0, SIN_RANDOM, 1'b0);
      csr_write(CSR_HALF_BIT, 32'd1);
      run_command(ACT_WRITE, 11'h7FF, 8'hFF, 3, SIN_RANDOM, 1'b0);
      run_command(ACT_READ, 11'h7FF, 8'h00, 0, SIN_HIGH, 1'b0);
      run_command(ACT_READ, 11'h000, 8'hFF, 0, SIN_LOW, 1'b0);
      run_command(ACT_WRITE, 11'h000, 8'h00, 0, SIN_RANDOM, 1'b0);
      run_command(ACT_EWDS, 11'h7FF, 8'hFF, 0, SIN_RANDOM, 1'b0);
   endtask

   // commands and garbage codes arriving mid-command must be ignored
   task automatic test_busy_commands();
      run_command(ACT_READ, 11'h555, 8'hAA, 0, SIN_RANDOM, 1'b1);
      run_command(ACT_WRITE, 11'h2AA, 8'h55, 2, SIN_RANDOM, 1'b1);
   endtask

   task automatic test_half_bit_extremes();
      csr_write(CSR_HALF_BIT, 32'd1);
      run_command(ACT_READ, 11'h3C3, 8'h00, 0, SIN_RANDOM, 1'b0);
      csr_write(CSR_HALF_BIT, 32'd0);
      run_command(ACT_WRITE, 11'h1A5, 8'h5A, 2, SIN_RANDOM, 1'b0);
      run_command(ACT_EWEN, 11'h000, 8'h00, 0, SIN_RANDOM, 1'b0);
      csr_write(CSR_HALF_BIT, 32'd2);
      run_command(ACT_READ, 11'h0F0, 8'h00, 0, SIN_RANDOM, 1'b0);
      csr_write(CSR_HALF_BIT, 32'd1);
   endtask

   task automatic test_ready_timeout();
      csr_write(CSR_TIMEOUT, 32'd1);
      run_command(ACT_WRITE, 11'h010, 8'h81, NEVER_READY, SIN_RANDOM, 1'b0);
      csr_write(CSR_TIMEOUT, 32'd0);
      run_command(ACT_WRITE, 11'h020, 8'h18, NEVER_READY, SIN_RANDOM, 1'b0);
      // ready on the last tolerated tick, then one tick too late
      csr_write(CSR_TIMEOUT, 32'd30);
      run_command(ACT_WRITE, 11'h040, 8'h42, 29, SIN_RANDOM, 1'b0);
      run_command(ACT_WRITE, 11'h080, 8'h24, 30, SIN_RANDOM, 1'b0);
      csr_write(CSR_TIMEOUT, 32'hFF_FFFF);
      run_command(ACT_WRITE, 11'h100, 8'hC3, 5, SIN_RANDOM, 1'b0);
   endtask

   // receiver holds off while beats keep coming, so the input side stalls
   task automatic test_output_stall();
      drain_results();
      gaps_on = 1'b0;
      rsp_hold_cycles = 120;
      run_command(ACT_READ, 11'h6DB, 8'h00, 0, SIN_RANDOM, 1'b1);
      gaps_on = 1'b1;
   endtask

   function automatic logic [31:0] pick_half();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 32'd1;
      if (r < 80) return $urandom_range(2, 4);
      if (r < 90) return 32'd0;
      return $urandom_range(5, 12);
   endfunction

   function automatic logic [31:0] pick_limit();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 20) return 32'd1;
      return $urandom_range(2, 40);
   endfunction

   function automatic int pick_ready_wait();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return NEVER_READY;
      if (r < 60) return $urandom_range(0, 3);
      return $urandom_range(0, ready_limit_cfg + 2);
   endfunction

   task automatic test_random_traffic();
      int first;
      int cmds;
      int r;
      first = ticks_sent;
      cmds  = 0;
      while (ticks_sent - first < RANDOM_TICKS) begin
         if (cmds % 5 == 0) begin
            csr_write(CSR_HALF_BIT, pick_half());
            csr_write(CSR_TIMEOUT, pick_limit());
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         cmds++;
         r = $urandom_range(0, 99);
         if (r < 12) begin
            // stray ticks, possibly starting a command mid-sequence
            repeat ($urandom_range(1, 4))
               send_tick(ACTION_W'($urandom_range(0, ACT_CODES - 1)),
                         ADDR_W'($urandom_range(0, 2047)),
                         WDATA_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else begin
            run_command(ACTION_W'(ACT_READ + $urandom_range(0, 3)),
                        ADDR_W'($urandom_range(0, 2047)),
                        WDATA_W'($urandom_range(0, 255)), pick_ready_wait(), SIN_RANDOM,
                        1'($urandom_range(0, 1)));
         end
      end
      gaps_on = 1'b1;
   endtask

   // Receiver: long hold when asked, otherwise random stalls
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles--;
      end else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         stall_pick = pick_gap();
         rsp_tready <= (stall_pick == 0);
         if (stall_pick > 0) rsp_stall_left = stall_pick - 1;
      end
   end

   // Compare each taken result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat = rsp_tdata[$bits(rsp_fields_type)-1:0];
         if (expected_tick_q.size() == 0) begin
            note_mismatch($sformatf("rsp beat %0d with nothing expected", rsp_beats));
         end else begin
            want_beat = expected_tick_q.pop_front();
            check_field($sformatf("rsp beat %0d chip_select", rsp_beats),
                        got_beat.chip_select, want_beat.chip_select);
            check_field($sformatf("rsp beat %0d serial_clock", rsp_beats),
                        got_beat.serial_clock, want_beat.serial_clock);
            check_field($sformatf("rsp beat %0d serial_out", rsp_beats),
                        got_beat.serial_out, want_beat.serial_out);
            check_field($sformatf("rsp beat %0d busy", rsp_beats),
                        got_beat.busy, want_beat.busy);
            check_field($sformatf("rsp beat %0d done", rsp_beats),
                        got_beat.done, want_beat.done);
            check_field($sformatf("rsp beat %0d read_data", rsp_beats),
                        got_beat.read_data, want_beat.read_data);
            check_field($sformatf("rsp beat %0d status", rsp_beats),
                        got_beat.status, want_beat.status);
         end
         rsp_beats++;
      end
   end

   // Run limit
   initial begin
      #4000000;
      $display("microwire_eeprom_master_top: mismatch");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = ACT_NONE;
      rsp_tready     = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      seq_phase      = PH_IDLE;
      seq_frame      = '0;
      seq_bits_left  = '0;
      seq_delay      = '0;
      seq_wait_count = '0;
      seq_read_byte  = '0;
      seq_status     = 1'b0;
      seq_kind       = KIND_NONE;
      pin_cs         = 1'b0;
      pin_sk         = 1'b0;
      pin_di         = 1'b0;
      half_ticks_cfg  = HALF_W'(4);
      ready_limit_cfg = TIMEOUT_W'(100000);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_each_command();
      test_busy_commands();
      test_half_bit_extremes();
      test_ready_timeout();
      test_output_stall();
      test_random_traffic();
      drain_results();

      if (mismatches == 0)
         $display("microwire_eeprom_master_top: match");
      else
         $display("microwire_eeprom_master_top: mismatch");
      $finish;
   end

endmodule

// ----- microwire_eeprom_master_top.f -----
hw/rtl/mwem_pkg.sv
hw/rtl/mwem_seq.sv
hw/rtl/mwem_out_buf.sv
hw/rtl/microwire_eeprom_master_top.sv
tb/sv/microwire_eeprom_master_top_tb.sv
